// File: rtl/sid_pkg.sv
`timescale 1ns / 1ps

package sid_pkg;

	localparam int MAX_NODES_DEFAULT = 63;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] STATUS_OK      = 3'd0;
	localparam logic [2:0] STATUS_INVALID = 3'd1;
	localparam logic [2:0] STATUS_EMPTY   = 3'd2;
	localparam logic [2:0] STATUS_RANGE   = 3'd3;
	localparam logic [2:0] STATUS_DUP     = 3'd4;
	localparam logic [2:0] STATUS_GAP     = 3'd5;

	localparam logic [2:0] EXT_SEQ0 = 3'd0;
	localparam logic [2:0] EXT_SEQ1 = 3'd1;

	localparam int EXT_SEQ0_PORTS = 8;
	localparam int EXT_SEQ1_PORTS = 5;
	localparam int EXT_SEQ1_POS   = 8;
	localparam int NUM_PORTS      = 16;

	typedef struct packed {
		logic [31:0] quadlet;
		logic        starts_node;
		logic        ends_node;
		logic        ends_stream;
		logic        capture_valid;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  node_id;
		logic        link_on;
		logic        is_contender;
		logic        started_reset;
		logic [5:0]  gap_value;
		logic [2:0]  power_code;
		logic [1:0]  speed_bits;
		logic [31:0] port_codes;
		logic [4:0]  ports_used;
		logic [2:0]  status;
		logic        is_summary;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic        rec_valid;
		logic        sum_valid;
		logic [2:0]  status;
		logic [5:0]  node_id;
		logic        link_on;
		logic        is_contender;
		logic        started_reset;
		logic [5:0]  gap_value;
		logic [2:0]  power_code;
		logic [1:0]  speed_bits;
		logic [31:0] port_codes;
	} entry_t;

endpackage

// File: rtl/sid_if.sv
`timescale 1ns / 1ps

interface sid_in_if;
	logic             valid;
	logic             ready;
	sid_pkg::in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface sid_out_if;
	logic               valid;
	logic               ready;
	sid_pkg::out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/sid_front.sv
`timescale 1ns / 1ps

module sid_front #(
	parameter int MAX_NODES = sid_pkg::MAX_NODES_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	sid_in_if.sink          items,
	output logic            push_valid,
	input  logic            push_ready,
	output sid_pkg::entry_t push_data
);

	logic [63:0] ids_seen_q;
	logic [6:0]  counted_q;
	logic [5:0]  highest_q;
	logic [31:0] base_q;
	logic [25:0] ext_q;
	logic        inside_q;
	logic [2:0]  sticky_q;

	logic [63:0] ids_seen_n;
	logic [6:0]  counted_n;
	logic [5:0]  highest_n;
	logic [31:0] base_n;
	logic [25:0] ext_n;
	logic        inside_n;
	logic [2:0]  sticky_n;
	logic        rec_n;
	logic [2:0]  sum_status;
	logic [5:0]  id;
	logic [31:0] q;
	logic        acc;

	assign items.ready = push_ready;
	assign acc = items.valid && items.ready;
	assign q = items.data.quadlet;
	assign id = q[29:24];

	always_comb begin
		ids_seen_n = ids_seen_q;
		counted_n = counted_q;
		highest_n = highest_q;
		base_n = base_q;
		ext_n = ext_q;
		inside_n = inside_q;
		sticky_n = sticky_q;
		rec_n = 1'b0;
		sum_status = sid_pkg::STATUS_OK;

		if (items.data.starts_node) begin
			base_n = q;
			ext_n = '0;
			inside_n = 1'b1;
			if (sticky_q == sid_pkg::STATUS_OK) begin
				if ({1'b0, id} >= 7'(MAX_NODES)) begin
					sticky_n = sid_pkg::STATUS_RANGE;
				end else if (ids_seen_q[id]) begin
					sticky_n = sid_pkg::STATUS_DUP;
				end else begin
					ids_seen_n[id] = 1'b1;
					counted_n = counted_q + 7'd1;
					if (id > highest_q) begin
						highest_n = id;
					end
				end
			end
		end else if (inside_q) begin
			if (q[22:20] == sid_pkg::EXT_SEQ0) begin
				for (int p = 0; p < sid_pkg::EXT_SEQ0_PORTS; p++) begin
					ext_n[2*p +: 2] = q[16-2*p +: 2];
				end
			end else if (q[22:20] == sid_pkg::EXT_SEQ1) begin
				for (int p = 0; p < sid_pkg::EXT_SEQ1_PORTS; p++) begin
					ext_n[2*(sid_pkg::EXT_SEQ1_POS+p) +: 2] = q[16-2*p +: 2];
				end
			end
		end

		if (items.data.ends_node && inside_n) begin
			rec_n = (sticky_n == sid_pkg::STATUS_OK);
			inside_n = 1'b0;
		end

		if (!items.data.capture_valid) begin
			sum_status = sid_pkg::STATUS_INVALID;
		end else if (sticky_n != sid_pkg::STATUS_OK) begin
			sum_status = sticky_n;
		end else if (counted_n == 7'd0) begin
			sum_status = sid_pkg::STATUS_EMPTY;
		end else if ({1'b0, highest_n} + 7'd1 != counted_n) begin
			sum_status = sid_pkg::STATUS_GAP;
		end
	end

	always_comb begin
		push_data.rec_valid = rec_n;
		push_data.sum_valid = items.data.ends_stream;
		push_data.status = sum_status;
		push_data.node_id = base_n[29:24];
		push_data.link_on = base_n[22];
		push_data.is_contender = base_n[11];
		push_data.started_reset = base_n[1];
		push_data.gap_value = base_n[21:16];
		push_data.power_code = base_n[10:8];
		push_data.speed_bits = base_n[15:14];
		push_data.port_codes = {ext_n, base_n[3:2], base_n[5:4], base_n[7:6]};
	end

	assign push_valid = items.valid && (rec_n || items.data.ends_stream);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ids_seen_q <= '0;
			counted_q <= '0;
			highest_q <= '0;
			ext_q <= '0;
			inside_q <= 1'b0;
			sticky_q <= sid_pkg::STATUS_OK;
		end else if (acc) begin
			if (items.data.ends_stream) begin
				ids_seen_q <= '0;
				counted_q <= '0;
				highest_q <= '0;
				ext_q <= '0;
				inside_q <= 1'b0;
				sticky_q <= sid_pkg::STATUS_OK;
			end else begin
				ids_seen_q <= ids_seen_n;
				counted_q <= counted_n;
				highest_q <= highest_n;
				ext_q <= ext_n;
				inside_q <= inside_n;
				sticky_q <= sticky_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			base_q <= base_n;
		end
	end

	a_stream_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && items.data.ends_stream |=> counted_q == 7'd0 && sticky_q == sid_pkg::STATUS_OK
			&& ids_seen_q == '0)
		else $error("stream state not cleared after stream end");

	a_sticky_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sticky_q != sid_pkg::STATUS_OK && !(acc && items.data.ends_stream)
			|=> sticky_q == $past(sticky_q))
		else $error("sticky error changed inside a stream");

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		counted_q == 7'($countones(ids_seen_q)))
		else $error("node count differs from IDs marked");

endmodule

// File: rtl/sid_queue.sv
`timescale 1ns / 1ps

module sid_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  sid_pkg::entry_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output sid_pkg::entry_t pop_data
);

	localparam int AW = $clog2(sid_pkg::QUEUE_DEPTH);

	sid_pkg::entry_t mem [sid_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != (AW+1)'(sid_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(sid_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(sid_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(sid_pkg::QUEUE_DEPTH))
		else $error("queue overfilled");

endmodule

// File: rtl/sid_back.sv
`timescale 1ns / 1ps

module sid_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  sid_pkg::entry_t pop_data,
	sid_out_if.source       records
);

	sid_pkg::entry_t    cur_q;
	logic               cur_valid_q;
	sid_pkg::out_item_t out_q;
	logic               out_valid_q;

	sid_pkg::out_item_t nxt;
	logic               load_out;
	logic               cur_done;
	logic [4:0]         used;

	assign load_out = cur_valid_q && (!out_valid_q || records.ready);
	assign cur_done = load_out && (!cur_q.rec_valid || !cur_q.sum_valid);
	assign pop_ready = !cur_valid_q || cur_done;

	always_comb begin
		used = '0;
		for (int k = 0; k < sid_pkg::NUM_PORTS; k++) begin
			if (cur_q.port_codes[2*k +: 2] != 2'b00) begin
				used = 5'(k + 1);
			end
		end
	end

	always_comb begin
		nxt = '0;
		if (cur_q.rec_valid) begin
			nxt.node_id = cur_q.node_id;
			nxt.link_on = cur_q.link_on;
			nxt.is_contender = cur_q.is_contender;
			nxt.started_reset = cur_q.started_reset;
			nxt.gap_value = cur_q.gap_value;
			nxt.power_code = cur_q.power_code;
			nxt.speed_bits = cur_q.speed_bits;
			nxt.port_codes = cur_q.port_codes;
			nxt.ports_used = used;
			nxt.status = sid_pkg::STATUS_OK;
			nxt.is_summary = 1'b0;
			nxt.last = !cur_q.sum_valid;
		end else begin
			nxt.status = cur_q.status;
			nxt.is_summary = 1'b1;
			nxt.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_ready) begin
				cur_valid_q <= pop_valid;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (records.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready) begin
			cur_q <= pop_data;
		end else if (load_out) begin
			cur_q.rec_valid <= 1'b0;
		end
		if (load_out) begin
			out_q <= nxt;
		end
	end

	assign records.valid = out_valid_q;
	assign records.data = out_q;

	a_summary_blank: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid && records.data.is_summary |-> records.data.port_codes == '0
			&& records.data.ports_used == '0 && records.data.last)
		else $error("summary carries node fields");

	a_record_status: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid && !records.data.is_summary |-> records.data.status == sid_pkg::STATUS_OK)
		else $error("node record with non-zero status");

endmodule

// File: rtl/self_id_stream_parser.sv
`timescale 1ns / 1ps
// Path: a result reaches records through the queue, cur_q and the out_q register.
// Throughput: one quadlet per cycle while the queue has room; a quadlet that
// yields a record and a summary sends both in turn from the single output register.
// Reset: arst_n clears the ID bitmap, counters, sticky error and queue at once;
// no clearing pass follows.
module self_id_stream_parser #(
	parameter int MAX_NODES = sid_pkg::MAX_NODES_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	sid_in_if.sink    items,
	sid_out_if.source records
);

	logic            push_valid;
	logic            push_ready;
	sid_pkg::entry_t push_data;
	logic            pop_valid;
	logic            pop_ready;
	sid_pkg::entry_t pop_data;

	sid_front #(
		.MAX_NODES(MAX_NODES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	sid_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	sid_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.records(records)
	);

endmodule
